FILE: src/alias_table_builder_top_assert.svh
// ----------------------------------------------------------------------------
// Alias table builder assertion macros
// Shared assertion forms used by the alias table builder modules.
// ----------------------------------------------------------------------------
`ifndef ALIAS_TABLE_BUILDER_TOP_ASSERT_SVH
`define ALIAS_TABLE_BUILDER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ATB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("alias table builder assertion failed");
`define ATB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("alias table builder assertion failed");
`else
`define ATB_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ATB_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: src/atb_pkg.sv
// ----------------------------------------------------------------------------
// Alias table builder package
// Shared constants and the command and status bundles of the builder.
// ----------------------------------------------------------------------------
`default_nettype none

package atb_pkg;

    localparam int DEF_MAX_ENTRIES = 1024;
    localparam int WEIGHT_W        = 32;
    localparam int PROB_W          = 32;
    localparam int IDX_W           = 10;
    localparam int FRAC_W          = 32;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic load;         // Accept a weight.
        logic read;         // Accept a table read.
        logic build_start;  // Latch the zero flag, mark the table built.
        logic idx_clr;
        logic idx_inc;
        logic clr_wr;       // Clear one table entry.
        logic sc_rd;
        logic sc_mul;
        logic div_start;
        logic sc_wr;
        logic part_rd;
        logic part_push;
        logic pair_idx_rd;
        logic pair_w_rd;
        logic pair_upd;
        logic out_load;
    } atb_cmd_t;

    typedef struct packed {
        logic n_zero;
        logic sum_zero;
        logic idx_last;
        logic pair_more;
        logic div_done;
    } atb_status_t;

endpackage

`default_nettype wire

FILE: src/atb_div.sv
// ----------------------------------------------------------------------------
// Alias table builder divider
// Restoring divider, one quotient bit per cycle, for floor(num * 2^32 / den).
// ----------------------------------------------------------------------------
`default_nettype none
`include "alias_table_builder_top_assert.svh"

module atb_div
    import atb_pkg::*;
#(
    parameter int NUM_W = 43,
    parameter int DEN_W = 43,
    parameter int Q_W   = 43
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start_i,
    input  wire logic [NUM_W-1:0] num_i,
    input  wire logic [DEN_W-1:0] den_i,
    output logic                  done_o,
    output logic [Q_W-1:0]        quot_o
);

    localparam int DIVD_W = NUM_W + FRAC_W;
    localparam int STEP_W = $clog2(DIVD_W + 1);

    logic [DIVD_W-1:0] divd_reg, divd_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [Q_W-1:0]    q_reg, q_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    assign trial  = {rem_reg, divd_reg[DIVD_W-1]};
    assign ge     = trial >= {1'b0, den_reg};
    assign diff   = trial - {1'b0, den_reg};
    assign done_o = busy_reg && (step_reg == STEP_W'(DIVD_W - 1));
    assign quot_o = q_reg;

    always_comb begin
        divd_next = divd_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (start_i) begin
            divd_next = {num_i, FRAC_W'(0)};
            rem_next  = '0;
            den_next  = den_i;
            q_next    = '0;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            divd_next = {divd_reg[DIVD_W-2:0], 1'b0};
            rem_next  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            q_next    = {q_reg[Q_W-2:0], ge};
            step_next = step_reg + STEP_W'(1);
            if (done_o) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
        divd_reg <= divd_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        q_reg    <= q_next;
    end

    `ATB_ASSERT_NEXT(a_div_start_busy, aclk, aresetn, start_i, busy_reg)
    `ATB_ASSERT_IMP(a_div_no_restart, aclk, aresetn, busy_reg && !done_o, !start_i)

endmodule

`default_nettype wire

FILE: src/atb_datapath.sv
// ----------------------------------------------------------------------------
// Alias table builder datapath
// Weight, stack and table memories, counters, scaling and pairing arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none
`include "alias_table_builder_top_assert.svh"

module atb_datapath
    import atb_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire atb_cmd_t            cmd_i,
    output atb_status_t              stat_o,
    input  wire logic [WEIGHT_W-1:0] s_weight,
    input  wire logic [IDX_W-1:0]    s_index,
    output logic [PROB_W-1:0]        m_prob,
    output logic [IDX_W-1:0]         m_alias_res,
    output logic                     m_has_alias,
    output logic                     m_zero_sum
);

    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int IW  = $clog2(MAX_ENTRIES);
    localparam int WSW = WEIGHT_W + CW;
    localparam logic [WSW:0] ONE_UNIT = (WSW + 1)'(1) << FRAC_W;

    // Memories.
    logic [WSW-1:0]    wmem [MAX_ENTRIES];
    logic [IW-1:0]     smem [MAX_ENTRIES];
    logic [PROB_W-1:0] pmem [MAX_ENTRIES];
    logic [IW:0]       amem [MAX_ENTRIES];

    logic [WSW-1:0]    w_rda_reg, w_rdb_reg;
    logic [IW-1:0]     s_rda_reg, s_rdb_reg;
    logic [PROB_W-1:0] p_rd_reg;
    logic [IW:0]       a_rd_reg;

    // Control state.
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [WSW-1:0] sum_reg, sum_next;
    logic           ready_reg, ready_next;
    logic           zero_reg, zero_next;
    logic [CW-1:0]  i_reg, i_next;
    logic [CW-1:0]  small_reg, small_next;
    logic [CW-1:0]  large_reg, large_next;
    logic           rd_ok_reg;

    logic [WSW-1:0] prod_reg;
    logic [CW-1:0]  cnt_base;
    logic [WSW-1:0] sum_base;
    logic [CW:0]    i_plus;
    logic [31:0]    idx_ext;
    logic [31:0]    alias_ext;
    logic [WSW:0]   red_sum;
    logic [WSW-1:0] new_wl;
    logic           new_small;
    logic           push_small;
    logic           div_done;
    logic [WSW-1:0] quot;

    logic           w_we;
    logic [IW-1:0]  w_wa;
    logic [WSW-1:0] w_wd;
    logic           s_we;
    logic [IW-1:0]  s_wa;
    logic [IW-1:0]  s_wd;
    logic           e_we;
    logic [IW-1:0]  e_wa;
    logic [PROB_W-1:0] e_wp;
    logic [IW:0]    e_wal;
    logic [IW-1:0]  w_raa;

    assign cnt_base   = ready_reg ? '0 : cnt_reg;
    assign sum_base   = ready_reg ? '0 : sum_reg;
    assign i_plus     = {1'b0, i_reg} + (CW + 1)'(1);
    assign idx_ext    = 32'(s_index);
    assign red_sum    = {1'b0, w_rdb_reg} + {1'b0, w_rda_reg} - ONE_UNIT;
    assign new_wl     = red_sum[WSW-1:0];
    assign new_small  = (new_wl[WSW-1:FRAC_W] == '0);
    assign push_small = (w_rda_reg[WSW-1:FRAC_W] == '0);

    assign stat_o.n_zero    = (cnt_reg == '0);
    assign stat_o.sum_zero  = (sum_reg == '0);
    assign stat_o.idx_last  = (i_plus == {1'b0, cnt_reg});
    assign stat_o.pair_more = (small_reg != '0) && (large_reg != cnt_reg);
    assign stat_o.div_done  = div_done;

    atb_div #(
        .NUM_W (WSW),
        .DEN_W (WSW),
        .Q_W   (WSW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (cmd_i.div_start),
        .num_i   (prod_reg),
        .den_i   (sum_reg),
        .done_o  (div_done),
        .quot_o  (quot)
    );

    // Write port selection.
    always_comb begin
        w_we  = 1'b0;
        w_wa  = i_reg[IW-1:0];
        w_wd  = quot;
        s_we  = 1'b0;
        s_wa  = small_reg[IW-1:0];
        s_wd  = i_reg[IW-1:0];
        e_we  = 1'b0;
        e_wa  = i_reg[IW-1:0];
        e_wp  = '0;
        e_wal = '0;
        w_raa = i_reg[IW-1:0];
        if (cmd_i.load && (cnt_base < CW'(MAX_ENTRIES))) begin
            w_we = 1'b1;
            w_wa = cnt_base[IW-1:0];
            w_wd = WSW'(s_weight);
        end
        if (cmd_i.sc_wr) begin
            w_we = 1'b1;
        end
        if (cmd_i.clr_wr) begin
            e_we = 1'b1;
        end
        if (cmd_i.part_push) begin
            s_we = 1'b1;
            if (!push_small) begin
                s_wa = large_reg[IW-1:0] - IW'(1);
            end
        end
        if (cmd_i.pair_w_rd) begin
            w_raa = s_rda_reg;
        end
        if (cmd_i.pair_upd) begin
            w_we  = 1'b1;
            w_wa  = s_rdb_reg;
            w_wd  = new_wl;
            e_we  = 1'b1;
            e_wa  = s_rda_reg;
            e_wp  = w_rda_reg[PROB_W-1:0];
            e_wal = {1'b1, s_rdb_reg};
            s_we  = new_small;
            s_wa  = small_reg[IW-1:0] - IW'(1);
            s_wd  = s_rdb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (w_we) begin
            wmem[w_wa] <= w_wd;
        end
        if (cmd_i.sc_rd || cmd_i.part_rd || cmd_i.pair_w_rd) begin
            w_rda_reg <= wmem[w_raa];
        end
        if (cmd_i.pair_w_rd) begin
            w_rdb_reg <= wmem[s_rdb_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_we) begin
            smem[s_wa] <= s_wd;
        end
        if (cmd_i.pair_idx_rd) begin
            s_rda_reg <= smem[small_reg[IW-1:0] - IW'(1)];
            s_rdb_reg <= smem[large_reg[IW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (e_we) begin
            pmem[e_wa] <= e_wp;
            amem[e_wa] <= e_wal;
        end
        if (cmd_i.read) begin
            p_rd_reg <= pmem[idx_ext[IW-1:0]];
            a_rd_reg <= amem[idx_ext[IW-1:0]];
        end
    end

    always_comb begin
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        ready_next = ready_reg;
        zero_next  = zero_reg;
        i_next     = i_reg;
        small_next = small_reg;
        large_next = large_reg;
        if (cmd_i.load) begin
            ready_next = 1'b0;
            cnt_next   = cnt_base;
            sum_next   = sum_base;
            if (cnt_base < CW'(MAX_ENTRIES)) begin
                cnt_next = cnt_base + CW'(1);
                sum_next = sum_base + WSW'(s_weight);
            end
        end
        if (cmd_i.build_start) begin
            ready_next = 1'b1;
            zero_next  = (sum_reg == '0);
            small_next = '0;
            large_next = cnt_reg;
        end
        if (cmd_i.idx_clr) begin
            i_next = '0;
        end else if (cmd_i.idx_inc) begin
            i_next = i_reg + CW'(1);
        end
        if (cmd_i.part_push) begin
            if (push_small) begin
                small_next = small_reg + CW'(1);
            end else begin
                large_next = large_reg - CW'(1);
            end
        end
        if (cmd_i.pair_upd) begin
            if (new_small) begin
                large_next = large_reg + CW'(1);
            end else begin
                small_next = small_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            sum_reg   <= '0;
            ready_reg <= 1'b0;
            zero_reg  <= 1'b0;
            i_reg     <= '0;
            small_reg <= '0;
            large_reg <= '0;
        end else begin
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
            ready_reg <= ready_next;
            zero_reg  <= zero_next;
            i_reg     <= i_next;
            small_reg <= small_next;
            large_reg <= large_next;
        end
        if (cmd_i.read) begin
            rd_ok_reg <= ready_reg && (idx_ext < 32'(cnt_reg));
        end
        if (cmd_i.sc_mul) begin
            prod_reg <= WSW'(w_rda_reg[WEIGHT_W-1:0]) * WSW'(cnt_reg);
        end
    end

    // Output register.
    assign alias_ext = 32'(a_rd_reg[IW-1:0]);

    always_ff @(posedge aclk) begin
        if (cmd_i.out_load) begin
            m_prob      <= rd_ok_reg ? p_rd_reg : '0;
            m_has_alias <= rd_ok_reg && a_rd_reg[IW];
            m_alias_res <= (rd_ok_reg && a_rd_reg[IW]) ? alias_ext[IDX_W-1:0] : '0;
            m_zero_sum  <= zero_reg;
        end
    end

    `ATB_ASSERT_IMP(a_dp_stacks_apart, aclk, aresetn, 1'b1, small_reg <= large_reg)
    `ATB_ASSERT_IMP(a_dp_count_bound, aclk, aresetn, 1'b1, cnt_reg <= CW'(MAX_ENTRIES))

endmodule

`default_nettype wire

FILE: src/atb_ctrl.sv
// ----------------------------------------------------------------------------
// Alias table builder controller
// Sequences loads, reads and the build phases of the alias table.
// ----------------------------------------------------------------------------
`default_nettype none
`include "alias_table_builder_top_assert.svh"

module atb_ctrl
    import atb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_kind,
    input  wire logic        s_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output atb_cmd_t         cmd_o,
    input  wire atb_status_t stat_i
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_CLR,
        ST_SC_RD,
        ST_SC_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_SC_WR,
        ST_PART_RD,
        ST_PART_PUSH,
        ST_PAIR_IDX,
        ST_PAIR_W,
        ST_PAIR_UPD
    } state_t;

    state_t state_reg, state_next;
    logic   rd_pend_reg, rd_pend_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE) && !rd_pend_reg && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd_o        = '0;
        state_next   = state_reg;
        cmd_o.out_load = rd_pend_reg;
        rd_pend_next = 1'b0;
        m_valid_next = rd_pend_reg || (m_valid_reg && !m_ready);
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_kind == KIND_LOAD) begin
                        cmd_o.load = 1'b1;
                        if (s_last) begin
                            state_next = ST_START;
                        end
                    end else begin
                        cmd_o.read   = 1'b1;
                        rd_pend_next = 1'b1;
                    end
                end
            end
            ST_START: begin
                cmd_o.build_start = 1'b1;
                cmd_o.idx_clr     = 1'b1;
                state_next = stat_i.n_zero ? ST_IDLE : ST_CLR;
            end
            ST_CLR: begin
                cmd_o.clr_wr  = 1'b1;
                cmd_o.idx_inc = 1'b1;
                if (stat_i.idx_last) begin
                    cmd_o.idx_clr = 1'b1;
                    state_next = stat_i.sum_zero ? ST_IDLE : ST_SC_RD;
                end
            end
            ST_SC_RD: begin
                cmd_o.sc_rd = 1'b1;
                state_next  = ST_SC_MUL;
            end
            ST_SC_MUL: begin
                cmd_o.sc_mul = 1'b1;
                state_next   = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                cmd_o.div_start = 1'b1;
                state_next      = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (stat_i.div_done) begin
                    state_next = ST_SC_WR;
                end
            end
            ST_SC_WR: begin
                cmd_o.sc_wr   = 1'b1;
                cmd_o.idx_inc = 1'b1;
                state_next    = ST_SC_RD;
                if (stat_i.idx_last) begin
                    cmd_o.idx_clr = 1'b1;
                    state_next    = ST_PART_RD;
                end
            end
            ST_PART_RD: begin
                cmd_o.part_rd = 1'b1;
                state_next    = ST_PART_PUSH;
            end
            ST_PART_PUSH: begin
                cmd_o.part_push = 1'b1;
                cmd_o.idx_inc   = 1'b1;
                state_next = stat_i.idx_last ? ST_PAIR_IDX : ST_PART_RD;
            end
            ST_PAIR_IDX: begin
                if (stat_i.pair_more) begin
                    cmd_o.pair_idx_rd = 1'b1;
                    state_next = ST_PAIR_W;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAIR_W: begin
                cmd_o.pair_w_rd = 1'b1;
                state_next      = ST_PAIR_UPD;
            end
            ST_PAIR_UPD: begin
                cmd_o.pair_upd = 1'b1;
                state_next     = ST_PAIR_IDX;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `ATB_ASSERT_IMP(a_ctrl_slot_free, aclk, aresetn, rd_pend_reg, !m_valid_reg)
    `ATB_ASSERT_NEXT(a_ctrl_read_result, aclk, aresetn, rd_pend_reg, m_valid_reg)

endmodule

`default_nettype wire

FILE: src/alias_table_builder_top.sv
// ----------------------------------------------------------------------------
// Alias table builder top level
// Builds an alias table from loaded weights and answers entry reads.
// ----------------------------------------------------------------------------
// Usage: the input channel (s_*) carries two kinds of transaction. A load
// transaction (s_kind = 0) appends s_weight to the weight set (at most
// MAX_ENTRIES weights); loads are taken one per cycle while no read is in
// flight or stalled. The load with s_last set starts the build, during which
// s_ready stays low. The build clears the used entries and, unless the sum
// is zero, scales each weight with a bit-serial divider, sorts indices onto
// the two stacks and pairs them. A read transaction (s_kind = 1) returns one
// entry on the output channel (m_*); the entry is read into registers, then
// loaded into the output register, and no transaction is taken in between.
// A load after a build discards the old set. When the receiver stalls, the
// result is held in the output register and no new transaction is taken
// until the slot is free. Reset is synchronous and active low; it clears
// the counters, the sum and the built flag. The memories need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module alias_table_builder_top
    import atb_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_kind,
    input  wire logic [WEIGHT_W-1:0] s_weight,
    input  wire logic                s_last,
    input  wire logic [IDX_W-1:0]    s_index,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [PROB_W-1:0]        m_prob,
    output logic [IDX_W-1:0]         m_alias_res,
    output logic                     m_has_alias,
    output logic                     m_zero_sum
);

    // Commands from the controller and status back from the datapath.
    atb_cmd_t    cmd;
    atb_status_t stat;

    atb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .s_last  (s_last),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd_o   (cmd),
        .stat_i  (stat)
    );

    // The datapath owns all memories and the output payload register.
    atb_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_i       (cmd),
        .stat_o      (stat),
        .s_weight    (s_weight),
        .s_index     (s_index),
        .m_prob      (m_prob),
        .m_alias_res (m_alias_res),
        .m_has_alias (m_has_alias),
        .m_zero_sum  (m_zero_sum)
    );

endmodule

`default_nettype wire

FILE: dv/tb_alias_table_builder_top.sv
// ----------------------------------------------------------------------------
// Alias table builder testbench
// Loads weight sets of varied size and shape, builds alias tables, reads the
// entries back and checks every read against a predicted table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Scoreboard: keeps its own copy of the weight set and the built table, and
// the queue of entry reads that are still owed by the block.
class alias_scoreboard;
    typedef struct packed {
        logic [31:0] prob;
        logic [9:0]  alias_idx;
        logic        has_alias;
        logic        zero_sum;
    } entry_t;

    logic [63:0] weights[1024];
    logic [31:0] tbl_prob[1024];
    logic [9:0]  tbl_alias[1024];
    bit          tbl_has[1024];
    logic [63:0] wsum;
    int          count;
    bit          sum_zero;
    bit          built;
    entry_t      pending[$];
    int          errors;
    int          reads_checked;
    int          builds;

    function new();
        wsum = 0; count = 0; sum_zero = 0; built = 0; errors = 0;
        reads_checked = 0; builds = 0;
    endfunction

    // floor(w * n * 2^32 / s) by division on 128-bit values.
    function automatic logic [63:0] normalize(logic [63:0] w, int n, logic [63:0] s);
        logic [127:0] num;
        num = ({64'd0, w} * n) << 32;
        return num / s;
    endfunction

    function void build();
        int small_stk[$];
        int large_stk[$];
        int s;
        int l;
        builds++;
        for (int i = 0; i < count; i++) begin
            tbl_prob[i] = 0; tbl_alias[i] = 0; tbl_has[i] = 0;
        end
        sum_zero = (wsum == 0);
        built = 1;
        if (sum_zero || count == 0) return;
        for (int i = 0; i < count; i++) weights[i] = normalize(weights[i], count, wsum);
        // Large entries are pushed from the top down, so the pair loop takes
        // the most recently pushed large entry first.
        for (int i = 0; i < count; i++) begin
            if (weights[i] < 64'h1_0000_0000) small_stk.push_back(i);
            else large_stk.push_front(i);
        end
        while (small_stk.size() > 0 && large_stk.size() > 0) begin
            s = small_stk.pop_back();
            l = large_stk[0];
            tbl_prob[s] = weights[s][31:0];
            tbl_alias[s] = l[9:0];
            tbl_has[s] = 1;
            weights[l] = weights[l] - (64'h1_0000_0000 - weights[s]);
            if (weights[l] < 64'h1_0000_0000) begin
                void'(large_stk.pop_front());
                small_stk.push_back(l);
            end
        end
    endfunction

    function void note_input(bit kind, logic [31:0] w, bit last, logic [9:0] idx);
        entry_t e;
        if (kind == atb_pkg::KIND_LOAD) begin
            if (built) begin
                built = 0; count = 0; wsum = 0;
            end
            if (count < 1024) begin
                weights[count] = {32'd0, w};
                wsum += w;
                count++;
            end
            if (last) build();
        end else begin
            e = '0;
            if (built && idx < count) begin
                e.prob = tbl_prob[idx];
                e.has_alias = tbl_has[idx];
                e.alias_idx = tbl_has[idx] ? tbl_alias[idx] : 10'd0;
            end
            e.zero_sum = sum_zero;
            pending.push_back(e);
        end
    endfunction

    function void check_result(logic [31:0] p, logic [9:0] a, bit h, bit z);
        entry_t e;
        if (pending.size() == 0) begin
            $error("result with no read outstanding");
            errors++;
            return;
        end
        e = pending.pop_front();
        reads_checked++;
        if (p !== e.prob) begin
            $error("prob expected %0h actual %0h", e.prob, p); errors++;
        end
        if (a !== e.alias_idx) begin
            $error("alias_res expected %0d actual %0d", e.alias_idx, a); errors++;
        end
        if (h !== e.has_alias) begin
            $error("has_alias expected %0d actual %0d", e.has_alias, h); errors++;
        end
        if (z !== e.zero_sum) begin
            $error("zero_sum expected %0d actual %0d", e.zero_sum, z); errors++;
        end
    endfunction
endclass

module tb_alias_table_builder_top;
    import atb_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic        s_kind = 0;
    logic [31:0] s_weight = 0;
    logic        s_last = 0;
    logic [9:0]  s_index = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [31:0] m_prob;
    logic [9:0]  m_alias_res;
    logic        m_has_alias;
    logic        m_zero_sum;

    // Idle percentages for the sender and the receiver; changed per phase.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int items_sent = 0;

    alias_scoreboard sb = new();

    alias_table_builder_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_weight(s_weight), .s_last(s_last), .s_index(s_index),
        .m_valid(m_valid), .m_ready(m_ready), .m_prob(m_prob),
        .m_alias_res(m_alias_res), .m_has_alias(m_has_alias),
        .m_zero_sum(m_zero_sum)
    );

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    // The receiver's ready is redrawn at every falling edge, and results are
    // checked at the rising edge where the transaction completes.
    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_prob, m_alias_res, m_has_alias, m_zero_sum);
    end

    // Drive one transaction: optional idle gap, then hold valid until the
    // block accepts it. The input is noted at the accepting edge. Valid is
    // left high on return; the next call or the caller takes it down.
    task automatic send_item(bit kind, logic [31:0] w, bit last, logic [9:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_valid  <= 1;
        s_kind   <= kind;
        s_weight <= w;
        s_last   <= last;
        s_index  <= idx;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(kind, w, last, idx);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic load_weight(logic [31:0] w, bit last);
        send_item(KIND_LOAD, w, last, 10'($urandom));
    endtask

    task automatic read_entry(logic [9:0] idx);
        send_item(KIND_READ, $urandom, 1'($urandom_range(1)), idx);
    endtask

    function automatic logic [31:0] rand_weight(int shape);
        case (shape)
            0: return $urandom;
            1: return $urandom_range(15);
            2: return ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom_range(1000);
            default: return $urandom >> $urandom_range(31);
        endcase
    endfunction

    // A full set: n loads with the last one marked, then reads of every built
    // entry plus up to two reads of indexes past the end of the set.
    task automatic build_and_read(int n, int shape);
        for (int i = 0; i < n; i++) load_weight(rand_weight(shape), i == n - 1);
        for (int i = 0; i < n; i++) read_entry(10'(i));
        repeat ($urandom_range(2)) read_entry(10'($urandom_range(1023, n)));
    endtask

    initial begin
        int n;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // Directed part: reads before any build, a zero sum, extreme weights,
        // leftover entries and a read past the end.
        read_entry(10'd0);
        read_entry(10'd1023);
        load_weight(32'd0, 0);
        load_weight(32'd0, 1);
        read_entry(10'd0);
        read_entry(10'd1);
        load_weight(32'hFFFF_FFFF, 0);
        load_weight(32'hFFFF_FFFF, 0);
        load_weight(32'd1, 1);
        read_entry(10'd0);
        read_entry(10'd1);
        read_entry(10'd2);
        read_entry(10'd3);
        load_weight(32'd5, 1);
        read_entry(10'd0);
        load_weight(32'd1, 0);
        load_weight(32'd2, 0);
        load_weight(32'd3, 0);
        load_weight(32'hFFFF_FFFF, 1);
        for (int i = 0; i < 4; i++) read_entry(10'(i));

        // Random phases with different idling, small sets mostly.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 35 : 58) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 35 : 58) : 0;
            while (items_sent < 40 + (ph + 1) * 250) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(1, 8);
                if ($urandom_range(7) == 0) begin
                    // Noise: stray reads in the middle of loading a set.
                    load_weight(rand_weight(0), 0);
                    read_entry(10'($urandom));
                end
                build_and_read(n, $urandom_range(3));
            end
        end
        s_valid <= 0;

        while (sb.pending.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("Checked %0d entry reads over %0d table builds, %0d transactions sent.",
                 sb.reads_checked, sb.builds, items_sent);
        if (sb.errors == 0) $display("alias_table_builder_top test passed");
        else $display("alias_table_builder_top test failed");
        $finish;
    end

    // Watchdog: builds of the larger sets dominate; this is several times the
    // slowest expected run.
    initial begin
        #50ms;
        $display("alias_table_builder_top test failed");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+src
src/atb_pkg.sv
src/atb_div.sv
src/atb_datapath.sv
src/atb_ctrl.sv
src/alias_table_builder_top.sv
dv/tb_alias_table_builder_top.sv
